@@ src/idmh_pkg.sv @@
// Shared types, constants and the parent-index reciprocal table for the indexed d-ary min-heap.
`default_nettype none
package idmh_pkg;

  localparam int unsigned HeapCap  = 1024;
  localparam int unsigned IdSpace  = 1024;
  localparam int unsigned MaxArity = 8;

  localparam int unsigned IdW     = $clog2(IdSpace);
  localparam int unsigned SlotW   = $clog2(HeapCap);
  localparam int unsigned CntW    = $clog2(HeapCap + 1);
  localparam int unsigned WeightW = 32;
  localparam int unsigned ArityW  = 4;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatW   = 3;

  // Parent index is (x * recip(d)) >> RecipShift, exact for every slot below capacity.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = RecipShift;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DECREASE = 2'd1,
    REQ_EXTRACT  = 2'd2,
    REQ_NOP      = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_HELD = 3'd2,
    ST_RISE     = 3'd3,
    ST_DUP      = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // One heap slot: the id it holds and its weight.
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [WeightW-1:0] weight;
  } slot_t;

  // One position map entry: held flag and slot number.
  typedef struct packed {
    logic             held;
    logic [SlotW-1:0] slot;
  } pos_t;

  // Rounded-up reciprocal of the arity, scaled by 2^RecipShift.
  function automatic logic [RecipW-1:0] recip(input logic [ArityW-1:0] d);
    logic [RecipW-1:0] r;
    case (d)
      4'd3:    r = 20'd349526;
      4'd4:    r = 20'd262144;
      4'd5:    r = 20'd209716;
      4'd6:    r = 20'd174763;
      4'd7:    r = 20'd149797;
      4'd8:    r = 20'd131072;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/indexed_dary_min_heap.sv @@
// Indexed d-ary min-heap with decrease-key: sequencer, heap memory and position map.
//
//  port group      dir  beat contents
//  s_axis_*        in   tuser: req_type; tdata: node_id, key_weight
//  m_axis_*        out  tuser: status; tdata: result_id, result_weight, entry_count
//  cfg_*           in   arity, written whenever cfg_we_i is high
//
// Insert climbs level by level, comparing with each parent; decrease first checks the current
// weight. Extract moves the last entry to the root and scans the children of each level it
// descends; errors and an extract that empties the heap answer without a walk. Each parent
// or child is fetched in its own cycle.
// After reset the position map is cleared in one pass, with tready low; a waiting result
// does not block the next request, and each item ends in the idle state, which raises tready.
`default_nettype none
module indexed_dary_min_heap (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [idmh_pkg::ArityW-1:0]      cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [47:0]                      s_axis_tdata,  // node_id, key_weight
  input  wire logic [idmh_pkg::ReqW-1:0]        s_axis_tuser,  // req_type
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [55:0]                           m_axis_tdata,  // result_id, result_weight,
                                                               // entry_count
  output logic [idmh_pkg::StatW-1:0]            m_axis_tuser   // status
);
  import idmh_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_CHK, S_DEC2, S_EXT2,
    S_SU_START, S_SU_CMP, S_SD_START, S_SD_SCAN, S_SD_DEC, S_PLACE, S_DONE
  } state_e;

  localparam int unsigned ProdW = ArityW + SlotW;

  // Memories
  slot_t hmem [HeapCap];
  pos_t  pmem [IdSpace];
  slot_t hrd_q;
  pos_t  prd_q;

  logic [SlotW-1:0] hm_raddr, hm_waddr;
  logic             hm_we;
  slot_t            hm_wdata;
  logic [IdW-1:0]   pm_raddr, pm_waddr;
  logic             pm_we;
  pos_t             pm_wdata;

  // Registers
  state_e state_q, state_d;
  logic [IdW-1:0]     clr_q, clr_d;
  req_e               req_q, req_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [WeightW-1:0] w_q, w_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SlotW-1:0]   at_q, at_d;
  slot_t              mv_q, mv_d;
  slot_t              best_q, best_d;
  logic [SlotW-1:0]   best_idx_q, best_idx_d;
  logic [SlotW-1:0]   k_q, k_d;
  logic [SlotW-1:0]   last_q, last_d;
  logic [SlotW-1:0]   par_q, par_d;
  logic               scan_first_q, scan_first_d;
  status_e            status_q, status_d;
  logic [IdW-1:0]     rid_q, rid_d;
  logic [WeightW-1:0] rw_q, rw_d;
  logic [ArityW-1:0]  arity_q, arity_d;
  logic               ovalid_q, ovalid_d;
  logic [55:0]        odata_q, odata_d;
  status_e            ouser_q, ouser_d;

  // Arithmetic
  logic [ArityW-1:0]        eff_d;
  logic [ProdW-1:0]         prod;
  logic [ProdW-1:0]         first_c, lastc_c;
  logic [SlotW-1:0]         upx;
  logic [SlotW+RecipW-1:0]  up_prod;
  logic [SlotW-1:0]         parent_c;

  // Clamp the arity register
  always_comb begin
    if (arity_q < ArityW'(2)) begin
      eff_d = ArityW'(2);
    end else if (arity_q > ArityW'(MaxArity)) begin
      eff_d = ArityW'(MaxArity);
    end else begin
      eff_d = arity_q;
    end
  end

  // Child range and parent index of the current slot
  assign prod     = ProdW'(eff_d) * ProdW'(at_q);
  assign first_c  = prod + ProdW'(1);
  assign lastc_c  = prod + ProdW'(eff_d);
  assign upx      = at_q - SlotW'(1);
  assign up_prod  = (SlotW+RecipW)'(upx) * (SlotW+RecipW)'(recip(eff_d));
  assign parent_c = up_prod[RecipShift +: SlotW];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    req_d        = req_q;
    id_d         = id_q;
    w_d          = w_q;
    cnt_d        = cnt_q;
    at_d         = at_q;
    mv_d         = mv_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    k_d          = k_q;
    last_d       = last_q;
    par_d        = par_q;
    scan_first_d = scan_first_q;
    status_d     = status_q;
    rid_d        = rid_q;
    rw_d         = rw_q;
    arity_d      = cfg_we_i ? cfg_wdata_i : arity_q;
    ovalid_d     = ovalid_q & ~m_axis_tready;
    odata_d      = odata_q;
    ouser_d      = ouser_q;
    hm_raddr     = '0;
    hm_we        = 1'b0;
    hm_waddr     = at_q;
    hm_wdata     = mv_q;
    pm_raddr     = id_q;
    pm_we        = 1'b0;
    pm_waddr     = mv_q.id;
    pm_wdata     = '{held: 1'b1, slot: at_q};
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = '{held: 1'b0, slot: '0};
        clr_d    = clr_q + IdW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d    = req_e'(s_axis_tuser);
          id_d     = s_axis_tdata[IdW-1:0];
          w_d      = s_axis_tdata[IdW +: WeightW];
          rid_d    = '0;
          rw_d     = '0;
          status_d = ST_OK;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        // fetch the map entry of the id and the root slot
        pm_raddr = id_q;
        hm_raddr = '0;
        state_d  = S_CHK;
      end
      S_CHK: begin
        unique case (req_q)
          REQ_INSERT: begin
            if (prd_q.held) begin
              status_d = ST_DUP;
              state_d  = S_DONE;
            end else if (cnt_q == CntW'(HeapCap)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              at_d    = cnt_q[SlotW-1:0];
              cnt_d   = cnt_q + CntW'(1);
              mv_d    = '{id: id_q, weight: w_q};
              state_d = S_SU_START;
            end
          end
          REQ_DECREASE: begin
            if (!prd_q.held) begin
              status_d = ST_NOT_HELD;
              state_d  = S_DONE;
            end else begin
              hm_raddr = prd_q.slot;
              at_d     = prd_q.slot;
              mv_d     = '{id: id_q, weight: w_q};
              state_d  = S_DEC2;
            end
          end
          REQ_EXTRACT: begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              rid_d    = hrd_q.id;
              rw_d     = hrd_q.weight;
              pm_we    = 1'b1;
              pm_waddr = hrd_q.id;
              pm_wdata = '{held: 1'b0, slot: '0};
              cnt_d    = cnt_q - CntW'(1);
              hm_raddr = SlotW'(cnt_q - CntW'(1));
              state_d  = (cnt_q == CntW'(1)) ? S_DONE : S_EXT2;
            end
          end
          REQ_NOP: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DEC2: begin
        if ($signed(w_q) > $signed(hrd_q.weight)) begin
          status_d = ST_RISE;
          state_d  = S_DONE;
        end else begin
          state_d = S_SU_START;
        end
      end
      S_EXT2: begin
        // last entry moves to the root
        mv_d    = hrd_q;
        at_d    = '0;
        state_d = S_SD_START;
      end
      S_SU_START: begin
        if (at_q == '0) begin
          state_d = S_PLACE;
        end else begin
          hm_raddr = parent_c;
          par_d    = parent_c;
          state_d  = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if ($signed(hrd_q.weight) <= $signed(mv_q.weight)) begin
          state_d = S_PLACE;
        end else begin
          // pull the parent down into the hole
          hm_we    = 1'b1;
          hm_wdata = hrd_q;
          pm_we    = 1'b1;
          pm_waddr = hrd_q.id;
          at_d     = par_q;
          state_d  = S_SU_START;
        end
      end
      S_SD_START: begin
        if (first_c >= ProdW'(cnt_q)) begin
          state_d = S_PLACE;
        end else begin
          hm_raddr     = first_c[SlotW-1:0];
          k_d          = first_c[SlotW-1:0];
          scan_first_d = 1'b1;
          if (lastc_c >= ProdW'(cnt_q)) begin
            last_d = SlotW'(cnt_q - CntW'(1));
          end else begin
            last_d = lastc_c[SlotW-1:0];
          end
          state_d = S_SD_SCAN;
        end
      end
      S_SD_SCAN: begin
        // keep the first strictly smallest child
        scan_first_d = 1'b0;
        if (scan_first_q || ($signed(hrd_q.weight) < $signed(best_q.weight))) begin
          best_d     = hrd_q;
          best_idx_d = k_q;
        end
        if (k_q < last_q) begin
          hm_raddr = k_q + SlotW'(1);
          k_d      = k_q + SlotW'(1);
        end else begin
          state_d = S_SD_DEC;
        end
      end
      S_SD_DEC: begin
        if ($signed(mv_q.weight) <= $signed(best_q.weight)) begin
          state_d = S_PLACE;
        end else begin
          // lift the child into the hole
          hm_we    = 1'b1;
          hm_wdata = best_q;
          pm_we    = 1'b1;
          pm_waddr = best_q.id;
          at_d     = best_idx_q;
          state_d  = S_SD_START;
        end
      end
      S_PLACE: begin
        hm_we   = 1'b1;
        pm_we   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {3'b000, cnt_q, rw_q, rid_q};
          ouser_d  = status_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      cnt_q    <= '0;
      arity_q  <= ArityW'(2);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      arity_q  <= arity_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    id_q         <= id_d;
    w_q          <= w_d;
    at_q         <= at_d;
    mv_q         <= mv_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    k_q          <= k_d;
    last_q       <= last_d;
    par_q        <= par_d;
    scan_first_q <= scan_first_d;
    status_q     <= status_d;
    rid_q        <= rid_d;
    rw_q         <= rw_d;
    odata_q      <= odata_d;
    ouser_q      <= ouser_d;
  end

  // Heap memory
  always_ff @(posedge clk_i) begin
    if (hm_we) begin
      hmem[hm_waddr] <= hm_wdata;
    end
    hrd_q <= hmem[hm_raddr];
  end

  // Position map
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pmem[pm_waddr] <= pm_wdata;
    end
    prd_q <= pmem[pm_raddr];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the indexed d-ary min-heap: directed and random request streams.
`default_nettype none
module testbench;
  import idmh_pkg::*;

  // One answer of the heap to a request
  typedef struct {
    status_e          status;
    logic [IdW-1:0]   rid;
    logic [31:0]      rweight;
    logic [CntW-1:0]  count;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ArityW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata = '0;  // node_id, key_weight
  logic [ReqW-1:0]   s_axis_tuser = '0;  // req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;       // result_id, result_weight, entry_count
  logic [StatW-1:0]  m_axis_tuser;       // status

  // Shadow heap state
  logic [IdW-1:0]       shadow_ids [HeapCap];
  logic signed [31:0]   shadow_weights [HeapCap];
  int unsigned          shadow_pos [IdSpace];
  bit                   shadow_held [IdSpace];
  int unsigned          shadow_count = 0;
  logic [ArityW-1:0]    shadow_arity = 4'd2;

  answer_t pending_answers[$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  int      ready_stall = 0;

  indexed_dary_min_heap i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned live_arity();
    if (shadow_arity < 2) return 2;
    if (shadow_arity > MaxArity) return MaxArity;
    return 32'(shadow_arity);
  endfunction

  function automatic void slot_swap(int unsigned a, int unsigned b);
    logic [IdW-1:0]     tid;
    logic signed [31:0] tw;
    tid = shadow_ids[a];
    tw = shadow_weights[a];
    shadow_ids[a] = shadow_ids[b];
    shadow_weights[a] = shadow_weights[b];
    shadow_ids[b] = tid;
    shadow_weights[b] = tw;
    shadow_pos[shadow_ids[a]] = a;
    shadow_pos[shadow_ids[b]] = b;
  endfunction

  // Climb while the parent is strictly heavier
  function automatic void bubble_up(int unsigned at);
    int unsigned d;
    int unsigned up;
    d = live_arity();
    while (at > 0) begin
      up = (at - 1) / d;
      if (shadow_weights[up] <= shadow_weights[at]) break;
      slot_swap(at, up);
      at = up;
    end
  endfunction

  // Descend to the first strictly lightest child while it is lighter
  function automatic void bubble_down(int unsigned at);
    int unsigned d;
    int unsigned first;
    int unsigned last;
    int unsigned best;
    d = live_arity();
    forever begin
      first = d * at + 1;
      if (first >= shadow_count) break;
      last = d * at + d;
      if (last >= shadow_count) last = shadow_count - 1;
      best = first;
      for (int unsigned k = first + 1; k <= last; k++) begin
        if (shadow_weights[k] < shadow_weights[best]) best = k;
      end
      if (shadow_weights[at] <= shadow_weights[best]) break;
      slot_swap(at, best);
      at = best;
    end
  endfunction

  function automatic answer_t heap_predict(req_e req, logic [IdW-1:0] id,
                                           logic signed [31:0] w);
    answer_t     a;
    int unsigned s;
    a.status = ST_OK;
    a.rid = '0;
    a.rweight = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_held[id]) begin
          a.status = ST_DUP;
        end else if (shadow_count >= HeapCap) begin
          a.status = ST_FULL;
        end else begin
          s = shadow_count;
          shadow_ids[s] = id;
          shadow_weights[s] = w;
          shadow_pos[id] = s;
          shadow_held[id] = 1'b1;
          shadow_count++;
          bubble_up(s);
        end
      end
      REQ_DECREASE: begin
        if (!shadow_held[id]) begin
          a.status = ST_NOT_HELD;
        end else begin
          s = shadow_pos[id];
          if (w > shadow_weights[s]) begin
            a.status = ST_RISE;
          end else begin
            shadow_weights[s] = w;
            bubble_up(s);
          end
        end
      end
      REQ_EXTRACT: begin
        if (shadow_count == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.rid = shadow_ids[0];
          a.rweight = shadow_weights[0];
          shadow_held[shadow_ids[0]] = 1'b0;
          shadow_count--;
          if (shadow_count > 0) begin
            shadow_ids[0] = shadow_ids[shadow_count];
            shadow_weights[0] = shadow_weights[shadow_count];
            shadow_pos[shadow_ids[0]] = 0;
            bubble_down(0);
          end
        end
      end
      default: ;
    endcase
    a.count = CntW'(shadow_count);
    return a;
  endfunction

  // Drive one request beat and predict its answer on acceptance
  task automatic send_request(req_e req, logic [IdW-1:0] id, logic [31:0] w);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {6'd0, w, id};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_answers.push_back(heap_predict(req, id, w));
  endtask

  // Hold the request side idle for a random burst now and then
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  // Random receiver stalls in bursts
  always @(negedge clk_i) begin
    if (ready_stall > 0) begin
      ready_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      ready_stall = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each answer beat with the oldest prediction
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected answer beat: status %0d", m_axis_tuser);
        mismatches++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (m_axis_tuser != exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[9:0] != exp_a.rid) begin
          $error("result_id: expected %0d, got %0d", exp_a.rid, m_axis_tdata[9:0]);
          mismatches++;
        end
        if (m_axis_tdata[41:10] != exp_a.rweight) begin
          $error("result_weight: expected %h, got %h", exp_a.rweight, m_axis_tdata[41:10]);
          mismatches++;
        end
        if (m_axis_tdata[52:42] != exp_a.count) begin
          $error("entry_count: expected %0d, got %0d", exp_a.count, m_axis_tdata[52:42]);
          mismatches++;
        end
      end
    end
  end

  // Lower valid and wait until every predicted answer has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_arity(logic [ArityW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_arity = value;
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Find a held id, scanning from a random start; the heap must not be empty
  function automatic logic [IdW-1:0] pick_held();
    int unsigned k;
    k = $urandom_range(0, IdSpace - 1);
    while (!shadow_held[k]) k = (k + 1) % IdSpace;
    return IdW'(k);
  endfunction

  task automatic test_directed();
    send_request(REQ_EXTRACT, 10'd0, 32'd0);
    send_request(REQ_DECREASE, 10'd7, 32'd0);
    send_request(REQ_NOP, 10'h3FF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 10'd0, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 10'h3FF, 32'h8000_0000);
    send_request(REQ_INSERT, 10'd512, 32'd0);
    send_request(REQ_INSERT, 10'd341, 32'h0001_0000);
    send_request(REQ_INSERT, 10'd682, 32'h0001_0000);
    send_request(REQ_INSERT, 10'd0, 32'd5);
    send_request(REQ_DECREASE, 10'd512, 32'd1);
    send_request(REQ_DECREASE, 10'd682, 32'h0001_0000);
    send_request(REQ_DECREASE, 10'd0, 32'hFFFF_0000);
    send_request(REQ_DECREASE, 10'd341, 32'h8000_0000);
    send_request(REQ_NOP, 10'd0, 32'd0);
    repeat (6) send_request(REQ_EXTRACT, 10'd0, 32'd0);
  endtask

  // Mostly well-formed traffic: inserts of random ids, legal decreases, extracts
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned roll;
    logic [IdW-1:0] id;
    for (int unsigned i = 0; i < n_items; i++) begin
      maybe_gap();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_request(REQ_INSERT, IdW'($urandom_range(0, IdSpace - 1)), pick_weight());
      end else if (roll < 68 && shadow_count > 0) begin
        id = pick_held();
        send_request(REQ_DECREASE, id,
                     (roll < 52) ? shadow_weights[shadow_pos[id]]
                                 : shadow_weights[shadow_pos[id]] - $urandom_range(0, 1000));
      end else if (roll < 90) begin
        send_request(REQ_EXTRACT, IdW'($urandom), $urandom);
      end else if (roll < 96) begin
        send_request(REQ_DECREASE, IdW'($urandom), $urandom);
      end else begin
        send_request(REQ_NOP, IdW'($urandom), $urandom);
      end
    end
  endtask

  // Walk several arities, the out-of-range codes and the extremes among them
  task automatic test_arities();
    logic [ArityW-1:0] arities[11] = '{4'd3, 4'd8, 4'd0, 4'd5, 4'd15, 4'd2,
                                       4'd1, 4'd4, 4'd9, 4'd6, 4'd7};
    foreach (arities[i]) begin
      write_arity(arities[i]);
      if (i == 10) quiet = 1'b1;
      test_random_traffic(175);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_arities();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    for (int c = 0; c < 200000 && pending_answers.size() != 0; c++) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $error("%0d answers never arrived", pending_answers.size());
      mismatches++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
src/idmh_pkg.sv
src/indexed_dary_min_heap.sv
tb/testbench.sv
